@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file of this project.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hdl/bli_pkg.sv @@
// Package of the bullet line break inserter: widths, character codes,
// the bullet symbol table, the match phase type and the command struct.
`timescale 1ns / 1ps

package bli_pkg;

  localparam int CpW  = 21;  // code point width
  localparam int CntW = 4;   // held digit count width, covers up to 15 digits

  localparam logic [CpW-1:0] CpNewline = CpW'(32'h0A);
  localparam logic [CpW-1:0] CpSpace   = CpW'(32'h20);
  localparam logic [CpW-1:0] CpPeriod  = CpW'(32'h2E);
  localparam logic [CpW-1:0] CpZero    = CpW'(32'h30);
  localparam logic [CpW-1:0] CpNine    = CpW'(32'h39);

  localparam int BulletCount = 38;

  localparam logic [CpW-1:0] BulletTable [BulletCount] = '{
    21'h02022, 21'h02023, 21'h025E6, 21'h02981, 21'h025CF, 21'h025AA, 21'h025AB, 21'h025FC,
    21'h025A0, 21'h02713, 21'h02714, 21'h02794, 21'h0279C, 21'h02792, 21'h0279E, 21'h027A0,
    21'h027A4, 21'h027A5, 21'h027A6, 21'h027A7, 21'h027A8, 21'h027A9, 21'h027AA, 21'h027AB,
    21'h027AC, 21'h027AD, 21'h027AE, 21'h027AF, 21'h027B1, 21'h027B2, 21'h027B3, 21'h027B5,
    21'h027B8, 21'h027BB, 21'h027BC, 21'h000B7, 21'h02027, 21'h030FB
  };

  // Match phase of a numbered bullet, one-hot
  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,  // nothing held
    PH_DIG  = 4'b0010,  // digits held
    PH_PER  = 4'b0100,  // digits and period held
    PH_SPC  = 4'b1000   // digits, period and space held
  } phase_e;

  // One command from the front to the back, emitted in field order:
  // newline, held digits, period, space, newline, the character itself.
  typedef struct packed {
    logic            nl_a;
    logic [CntW-1:0] ndig;
    logic            per;
    logic            spc;
    logic            nl_b;
    logic            chr;
    logic [CpW-1:0]  cp;
    logic            last;
  } cmd_ctl_t;

  function automatic logic bullet_match(logic [CpW-1:0] c);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < BulletCount; k++) begin
      if (BulletTable[k] == c) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

@@ hdl/bli_in_if.sv @@
// Input channel of the bullet line break inserter: valid, ready, one code point.
// Depends on bli_pkg.
`timescale 1ns / 1ps

interface bli_in_if
  import bli_pkg::*;
();
  logic           valid;
  logic           ready;
  logic [CpW-1:0] code_point;
  logic           end_of_text;

  modport source (output valid, code_point, end_of_text, input ready);
  modport sink   (input valid, code_point, end_of_text, output ready);
endinterface

@@ hdl/bli_out_if.sv @@
// Output channel of the bullet line break inserter: valid, ready, one code point.
// Depends on bli_pkg.
`timescale 1ns / 1ps

interface bli_out_if
  import bli_pkg::*;
();
  logic           valid;
  logic           ready;
  logic [CpW-1:0] out_char;
  logic           out_last;

  modport source (output valid, out_char, out_last, input ready);
  modport sink   (input valid, out_char, out_last, output ready);
endinterface

@@ hdl/bli_front.sv @@
// Front of the bullet line break inserter: accepts characters, tracks the
// numbered bullet match and issues commands. Depends on bli_pkg.
`timescale 1ns / 1ps

module bli_front
  import bli_pkg::*;
#(
  parameter int MAX_DIGITS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [CpW-1:0]              code_point_i,
  input  logic                        end_of_text_i,
  output logic                        push_o,
  input  logic                        push_ready_i,
  output cmd_ctl_t                    cmd_o,
  output logic [MAX_DIGITS-1:0][3:0]  digits_o
);

  localparam int IdxW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_DIGITS);

  logic                       ps_q, ps_d;
  phase_e                     phase_q, phase_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic [MAX_DIGITS-1:0][3:0] held_q;

  logic accept;
  logic is_dig, is_spc, is_per, is_bul;
  logic flush, cls, ps_cls, app, hold0, tail, any;
  logic [IdxW-1:0] wr_idx;
  logic [3:0]      dig_val;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign is_dig  = (code_point_i >= CpZero) && (code_point_i <= CpNine);
  assign is_spc  = (code_point_i == CpSpace);
  assign is_per  = (code_point_i == CpPeriod);
  assign is_bul  = bullet_match(code_point_i);
  assign dig_val = code_point_i[3:0];
  assign wr_idx  = cnt_q[IdxW-1:0];

  // Resolve the pending match, classify, then close the string on its last character
  always_comb begin
    flush   = 1'b0;
    cls     = 1'b0;
    ps_cls  = ps_q;
    app     = 1'b0;
    hold0   = 1'b0;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    ps_d    = ps_q;
    cmd_o   = '0;
    cmd_o.cp   = code_point_i;
    cmd_o.last = end_of_text_i;

    unique case (phase_q)
      PH_IDLE: cls = 1'b1;
      PH_DIG: begin
        if (is_dig && (cnt_q < MaxCnt)) begin
          app   = 1'b1;
          cnt_d = cnt_q + CntW'(1);
        end else if (is_per && !is_dig) begin
          phase_d = PH_PER;
        end else begin
          flush  = 1'b1;
          ps_cls = 1'b0;
          cls    = 1'b1;
        end
      end
      PH_PER: begin
        if (is_spc) begin
          phase_d = PH_SPC;
        end else begin
          flush  = 1'b1;
          ps_cls = 1'b0;
          cls    = 1'b1;
        end
      end
      PH_SPC: begin
        cmd_o.nl_a = 1'b1;
        flush      = 1'b1;
        ps_cls     = 1'b1;
        cls        = 1'b1;
      end
      default: cls = 1'b1;
    endcase

    if (flush) begin
      phase_d = PH_IDLE;
      cnt_d   = '0;
    end

    // Classify the character as if idle
    if (cls) begin
      priority if (is_bul) begin
        cmd_o.nl_b = 1'b1;
        cmd_o.chr  = 1'b1;
        ps_d       = 1'b0;
      end else if (is_dig && ps_cls) begin
        hold0   = 1'b1;
        phase_d = PH_DIG;
        cnt_d   = CntW'(1);
        ps_d    = 1'b0;
      end else begin
        cmd_o.chr = 1'b1;
        ps_d      = is_spc;
      end
    end

    // End of string: flush whatever is still held
    tail = end_of_text_i && !hold0 && (phase_d != PH_IDLE);
    if (end_of_text_i && hold0) cmd_o.chr = 1'b1;

    if (flush) begin
      cmd_o.ndig = cnt_q;
      cmd_o.per  = (phase_q == PH_PER) || (phase_q == PH_SPC);
      cmd_o.spc  = (phase_q == PH_SPC);
    end else if (tail) begin
      cmd_o.ndig = cnt_d;
      cmd_o.per  = (phase_d == PH_PER) || (phase_d == PH_SPC);
      cmd_o.spc  = (phase_d == PH_SPC);
    end

    if (end_of_text_i) begin
      phase_d = PH_IDLE;
      cnt_d   = '0;
      ps_d    = 1'b0;
    end

    // Held digits as seen by this command, with an appended digit included
    digits_o = held_q;
    if (app) digits_o[wr_idx] = dig_val;
  end

  assign any = cmd_o.nl_a || (cmd_o.ndig != '0) || cmd_o.per || cmd_o.spc ||
               cmd_o.nl_b || cmd_o.chr;
  assign push_o = accept && any;

  // Advance match state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ps_q    <= 1'b0;
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
    end else if (accept) begin
      ps_q    <= ps_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  // Hold digit values
  always_ff @(posedge clk_i) begin
    if (accept && app) held_q[wr_idx] <= dig_val;
    if (accept && hold0) held_q[0] <= dig_val;
  end

endmodule

@@ hdl/bli_queue.sv @@
// Two-entry command queue between front and back of the bullet line break
// inserter. Depends on bli_pkg.
`timescale 1ns / 1ps

module bli_queue
  import bli_pkg::*;
#(
  parameter int MAX_DIGITS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  output logic                        push_ready_o,
  input  cmd_ctl_t                    push_cmd_i,
  input  logic [MAX_DIGITS-1:0][3:0]  push_digits_i,
  output logic                        pop_valid_o,
  input  logic                        pop_i,
  output cmd_ctl_t                    pop_cmd_o,
  output logic [MAX_DIGITS-1:0][3:0]  pop_digits_o
);

  cmd_ctl_t                   cmd_q    [2];
  logic [MAX_DIGITS-1:0][3:0] digits_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;
  logic       do_push, do_pop;

  assign push_ready_o = (fill_q != 2'd2);
  assign pop_valid_o  = (fill_q != 2'd0);
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_cmd_o    = cmd_q[rd_ptr_q];
  assign pop_digits_o = digits_q[rd_ptr_q];

  // Track pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop) rd_ptr_q <= ~rd_ptr_q;
      if (do_push && !do_pop) fill_q <= fill_q + 2'd1;
      else if (do_pop && !do_push) fill_q <= fill_q - 2'd1;
    end
  end

  // Store request payload
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      cmd_q[wr_ptr_q]    <= push_cmd_i;
      digits_q[wr_ptr_q] <= push_digits_i;
    end
  end

endmodule

@@ hdl/bli_back.sv @@
// Back of the bullet line break inserter: expands one command into output
// characters, one per cycle while the output is not stalled, into an output register. Depends on bli_pkg.
`timescale 1ns / 1ps

module bli_back
  import bli_pkg::*;
#(
  parameter int MAX_DIGITS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  output logic                        cmd_pop_o,
  input  cmd_ctl_t                    cmd_i,
  input  logic [MAX_DIGITS-1:0][3:0]  digits_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [CpW-1:0]              out_char_o,
  output logic                        out_last_o
);

  localparam int IdxW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  logic                       nl_a_q, nl_a_d, per_q, per_d, spc_q, spc_d;
  logic                       nl_b_q, nl_b_d, chr_q, chr_d;
  logic [CntW-1:0]            rem_q, rem_d;
  logic [IdxW-1:0]            idx_q, idx_d;
  logic [MAX_DIGITS-1:0][3:0] digits_q;
  logic [CpW-1:0]             cp_q;
  logic                       last_q;

  logic           ov_q;
  logic [CpW-1:0] oc_q, oc_d;
  logic           ol_q, ol_d;
  logic           busy, busy_next, adv;

  assign busy      = nl_a_q || (rem_q != '0) || per_q || spc_q || nl_b_q || chr_q;
  assign adv       = busy && (!ov_q || out_ready_i);
  assign cmd_pop_o = !busy && cmd_valid_i;

  // Pick the next character of the current command
  always_comb begin
    nl_a_d = nl_a_q;
    rem_d  = rem_q;
    idx_d  = idx_q;
    per_d  = per_q;
    spc_d  = spc_q;
    nl_b_d = nl_b_q;
    chr_d  = chr_q;
    oc_d   = cp_q;
    priority if (nl_a_q) begin
      oc_d   = CpNewline;
      nl_a_d = 1'b0;
    end else if (rem_q != '0) begin
      oc_d  = CpZero + CpW'(digits_q[idx_q]);
      rem_d = rem_q - CntW'(1);
      idx_d = idx_q + IdxW'(1);
    end else if (per_q) begin
      oc_d  = CpPeriod;
      per_d = 1'b0;
    end else if (spc_q) begin
      oc_d  = CpSpace;
      spc_d = 1'b0;
    end else if (nl_b_q) begin
      oc_d   = CpNewline;
      nl_b_d = 1'b0;
    end else begin
      oc_d  = cp_q;
      chr_d = 1'b0;
    end
    busy_next = nl_a_d || (rem_d != '0) || per_d || spc_d || nl_b_d || chr_d;
    ol_d      = last_q && !busy_next;
  end

  // Load a command or step through it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nl_a_q <= 1'b0;
      rem_q  <= '0;
      idx_q  <= '0;
      per_q  <= 1'b0;
      spc_q  <= 1'b0;
      nl_b_q <= 1'b0;
      chr_q  <= 1'b0;
    end else if (cmd_pop_o) begin
      nl_a_q <= cmd_i.nl_a;
      rem_q  <= cmd_i.ndig;
      idx_q  <= '0;
      per_q  <= cmd_i.per;
      spc_q  <= cmd_i.spc;
      nl_b_q <= cmd_i.nl_b;
      chr_q  <= cmd_i.chr;
    end else if (adv) begin
      nl_a_q <= nl_a_d;
      rem_q  <= rem_d;
      idx_q  <= idx_d;
      per_q  <= per_d;
      spc_q  <= spc_d;
      nl_b_q <= nl_b_d;
      chr_q  <= chr_d;
    end
  end

  // Hold command payload
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      digits_q <= digits_i;
      cp_q     <= cmd_i.cp;
      last_q   <= cmd_i.last;
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (adv) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      oc_q <= oc_d;
      ol_q <= ol_d;
    end
  end

  assign out_valid_o = ov_q;
  assign out_char_o  = oc_q;
  assign out_last_o  = ol_q;

endmodule

@@ hdl/bullet_line_break_inserter.sv @@
// Top level of the bullet line break inserter: front, command queue and back.
// Depends on bli_pkg, bli_in_if, bli_out_if, bli_front, bli_queue, bli_back.
//
//   channel  dir  request content
//   in_i     in   code_point (21 bits), end_of_text (1 bit)
//   out_o    out  out_char (21 bits), out_last (1 bit)
//
// A character that yields k output characters occupies the back while it loads
// the command and then emits them one by one through the single-character
// output register. Digits being held emit nothing. An input character passes
// through the queue, the back's command registers and the output register.
// Reset is asynchronous, active low, and clears match state, queue and output.
// The two-entry queue lets the front accept while the back is stalled.
`timescale 1ns / 1ps

module bullet_line_break_inserter
  import bli_pkg::*;
#(
  parameter int MAX_DIGITS = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  bli_in_if.sink   in_i,
  bli_out_if.source out_o
);

  logic                       push, push_ready, q_valid, q_pop;
  cmd_ctl_t                   push_cmd, pop_cmd;
  logic [MAX_DIGITS-1:0][3:0] push_digits, pop_digits;

  bli_front #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .code_point_i (in_i.code_point),
    .end_of_text_i(in_i.end_of_text),
    .push_o       (push),
    .push_ready_i (push_ready),
    .cmd_o        (push_cmd),
    .digits_o     (push_digits)
  );

  bli_queue #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .push_digits_i(push_digits),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .pop_cmd_o    (pop_cmd),
    .pop_digits_o (pop_digits)
  );

  bli_back #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(q_valid),
    .cmd_pop_o  (q_pop),
    .cmd_i      (pop_cmd),
    .digits_i   (pop_digits),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .out_char_o (out_o.out_char),
    .out_last_o (out_o.out_last)
  );

endmodule

@@ hdl/bli_checker.sv @@
// Port-level checker for the bullet line break inserter, bound to the top.
// Depends on bli_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bli_checker
  import bli_pkg::*;
(
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_i,
  input logic           in_end_i,
  input logic           out_valid_i,
  input logic           out_ready_i,
  input logic [CpW-1:0] out_char_i,
  input logic           out_last_i
);

  logic       in_acc, out_acc;
  logic [2:0] open_q;
  logic       prev_nl_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // Count strings whose last character went in but whose last output is still due
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q    <= '0;
      prev_nl_q <= 1'b0;
    end else begin
      open_q <= open_q + 3'(in_acc && in_end_i) - 3'(out_acc && out_last_i);
      if (out_acc) prev_nl_q <= (out_char_i == CpNewline);
    end
  end

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_char_i) && $stable(out_last_i))
  `ASSERT_IMPL(a_bullet_nl, clk_i, rst_ni, out_acc && bullet_match(out_char_i), prev_nl_q)
  `ASSERT_IMPL(a_last_owed, clk_i, rst_ni, out_acc && out_last_i, open_q != 3'd0)

endmodule

bind bullet_line_break_inserter bli_checker u_bli_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .in_end_i   (in_i.end_of_text),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_char_i (out_o.out_char),
  .out_last_i (out_o.out_last)
);

@@ dv/tb_top.sv @@
// Testbench of bullet_line_break_inserter: directed and random strings, checked per output char.
// A scoreboard class predicts the inserted newlines and held digit flushes.
// Depends on bli_pkg, bli_in_if, bli_out_if and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
  import bli_pkg::*;

  localparam int HeldMax    = 8;     // MAX_DIGITS of the instance
  localparam int StallLimit = 5000;  // cycles without any handshake before giving up
  localparam int PhaseItems = 99;    // random text segments per idling phase at most

  localparam logic [CpW-1:0] BulletList [38] = '{
    21'h02022, 21'h02023, 21'h025E6, 21'h02981, 21'h025CF, 21'h025AA, 21'h025AB, 21'h025FC,
    21'h025A0, 21'h02713, 21'h02714, 21'h02794, 21'h0279C, 21'h02792, 21'h0279E, 21'h027A0,
    21'h027A4, 21'h027A5, 21'h027A6, 21'h027A7, 21'h027A8, 21'h027A9, 21'h027AA, 21'h027AB,
    21'h027AC, 21'h027AD, 21'h027AE, 21'h027AF, 21'h027B1, 21'h027B2, 21'h027B3, 21'h027B5,
    21'h027B8, 21'h027BB, 21'h027BC, 21'h000B7, 21'h02027, 21'h030FB
  };

  typedef enum logic [1:0] {
    MATCH_IDLE,
    MATCH_DIGITS,
    MATCH_PERIOD,
    MATCH_SPACE
  } match_e;

  typedef struct packed {
    logic [CpW-1:0] cp;
    logic           last;
  } out_char_t;

  // Predicts the output chars of each request and checks them in order
  class bullet_scoreboard;
    out_char_t   expected_q[$];
    int unsigned error_count;
    bit          after_space;
    match_e      phase;
    logic [3:0]  digit_buf[HeldMax];
    int unsigned digit_count;

    function new();
      error_count = 0;
      after_space = 1'b0;
      phase       = MATCH_IDLE;
      digit_count = 0;
    endfunction

    function void note_error(string msg);
      error_count++;
      if (error_count <= 10) $display("mismatch: %s", msg);
    endfunction

    function void push_char(logic [CpW-1:0] c);
      out_char_t entry;
      entry.cp   = c;
      entry.last = 1'b0;
      expected_q.insert(expected_q.size(), entry);
    endfunction

    function bit is_bullet_cp(logic [CpW-1:0] c);
      foreach (BulletList[k]) begin
        if (BulletList[k] == c) return 1'b1;
      end
      return 1'b0;
    endfunction

    function bit is_digit_cp(logic [CpW-1:0] c);
      return c >= CpZero && c <= CpNine;
    endfunction

    // Emit the held digits, period and space unchanged and drop the match
    function void release_held();
      for (int k = 0; k < digit_count; k++) push_char(CpZero + CpW'(digit_buf[k]));
      if (phase == MATCH_PERIOD || phase == MATCH_SPACE) push_char(CpPeriod);
      if (phase == MATCH_SPACE) push_char(CpSpace);
      phase       = MATCH_IDLE;
      digit_count = 0;
    endfunction

    // Handle a char with no match in progress
    function void classify(logic [CpW-1:0] c);
      if (is_bullet_cp(c)) begin
        push_char(CpNewline);
        push_char(c);
        after_space = 1'b0;
      end else if (is_digit_cp(c) && after_space) begin
        digit_buf[0] = 4'(c - CpZero);
        digit_count  = 1;
        phase        = MATCH_DIGITS;
        after_space  = 1'b0;
      end else begin
        push_char(c);
        after_space = (c == CpSpace);
      end
    endfunction

    function void note_char(logic [CpW-1:0] c, logic eot);
      int unsigned n_queued;
      n_queued = expected_q.size();
      case (phase)
        MATCH_DIGITS: begin
          if (is_digit_cp(c) && digit_count < HeldMax) begin
            digit_buf[digit_count] = 4'(c - CpZero);
            digit_count++;
          end else if (c == CpPeriod) begin
            phase = MATCH_PERIOD;
          end else begin
            release_held();
            after_space = 1'b0;
            classify(c);
          end
        end
        MATCH_PERIOD: begin
          if (c == CpSpace) begin
            phase = MATCH_SPACE;
          end else begin
            release_held();
            after_space = 1'b0;
            classify(c);
          end
        end
        MATCH_SPACE: begin
          // any char confirms the numbered bullet
          push_char(CpNewline);
          release_held();
          after_space = 1'b1;
          classify(c);
        end
        default: classify(c);
      endcase
      if (eot) begin
        if (phase != MATCH_IDLE) release_held();
        after_space = 1'b0;
        phase       = MATCH_IDLE;
        digit_count = 0;
        if (expected_q.size() > n_queued) expected_q[expected_q.size() - 1].last = 1'b1;
      end
    endfunction

    function void check_char(logic [CpW-1:0] c, logic l);
      out_char_t want;
      if (expected_q.size() == 0) begin
        note_error($sformatf("unexpected out_char %h out_last %b", c, l));
        return;
      end
      want = expected_q.pop_front();
      if (want.cp !== c || want.last !== l)
        note_error($sformatf("expected out_char %h out_last %b, got out_char %h out_last %b",
                             want.cp, want.last, c, l));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   items_sent;
  int   stall_cycles;

  bli_in_if  in_if();
  bli_out_if out_if();

  bullet_scoreboard sb = new();

  bullet_line_break_inserter #(
    .MAX_DIGITS(HeldMax)
  ) uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Stall the output at random
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Note accepted requests, check output chars, watch for a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) sb.note_char(in_if.code_point, in_if.end_of_text);
      if (out_if.valid && out_if.ready) sb.check_char(out_if.out_char, out_if.out_last);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= StallLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Offer one request, idling first at random, and hold it until accepted
  task automatic send_char(input logic [CpW-1:0] c, input logic eot);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.code_point  <= c;
    in_if.end_of_text <= eot;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    items_sent++;
  endtask

  // Send an ASCII string, end_of_text on its last char if asked
  task automatic send_text(input string s, input bit eot_at_end);
    for (int i = 0; i < s.len(); i++)
      send_char(CpW'(s[i]), eot_at_end && (i == s.len() - 1));
  endtask

  // Hold the input idle until every expected output char has come
  task automatic drain_wait();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (sb.expected_q.size() != 0);
  endtask

  function automatic logic end_roll();
    return ($urandom_range(24) == 0);
  endfunction

  function automatic logic [CpW-1:0] rand_digit();
    return CpZero + CpW'($urandom_range(9));
  endfunction

  function automatic logic [CpW-1:0] rand_char();
    case ($urandom_range(9))
      0, 1:    return CpW'($urandom_range(21'h1FFFFF));
      2, 3, 4: return CpW'($urandom_range(8'h7E, 8'h21));
      5:       return CpSpace;
      6:       return CpPeriod;
      7:       return rand_digit();
      8:       return BulletList[$urandom_range(37)];
      default: return BulletList[$urandom_range(37)] + CpW'(1);
    endcase
  endfunction

  // Send one random piece of text, often a numbered bullet
  task automatic send_segment();
    int n_digits;
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        n_digits = $urandom_range(HeldMax, 1);
        send_char(CpSpace, end_roll());
        repeat (n_digits) send_char(rand_digit(), end_roll());
        send_char(CpPeriod, end_roll());
        send_char(CpSpace, end_roll());
        send_char(rand_char(), end_roll());
      end
      4: begin
        // broken numbered bullet
        n_digits = $urandom_range(HeldMax, 1);
        send_char(CpSpace, end_roll());
        repeat (n_digits) send_char(rand_digit(), end_roll());
        if ($urandom_range(1)) send_char(CpPeriod, end_roll());
        send_char(rand_char(), end_roll());
      end
      5: begin
        send_char(BulletList[$urandom_range(37)], end_roll());
      end
      6, 7: begin
        repeat ($urandom_range(4, 1)) send_char(rand_char(), end_roll());
      end
      8: begin
        // digit run past the held limit
        send_char(CpSpace, end_roll());
        repeat ($urandom_range(HeldMax + 3, HeldMax + 1)) send_char(rand_digit(), end_roll());
      end
      default: send_char(rand_char(), 1'b1);
    endcase
  endtask

  initial begin
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    items_sent        = 0;
    stall_cycles      = 0;
    rst_n             <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.code_point  <= '0;
    in_if.end_of_text <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: string edges, extremes, bullets and numbered bullet corners
    send_text("0", 1'b1);
    send_char(21'h1FFFFF, 1'b0);
    send_char(21'h000000, 1'b1);
    send_char(21'h02022, 1'b1);
    send_text(" 98765432. ", 1'b0);
    send_char(21'h030FB, 1'b1);
    send_text(" 123456789", 1'b1);
    send_text(" 2.", 1'b1);
    send_text(" 4. ", 1'b1);
    drain_wait();

    // Random strings under each idling mix
    for (int m = 0; m < 4; m++) begin
      send_idle_pct  = (m == 1) ? 61 : (m == 3) ? 15 : 0;
      recv_stall_pct = (m == 2) ? 61 : (m == 3) ? 15 : 0;
      for (int n = 0; n < PhaseItems; n = n) begin
        send_segment();
        n = n + 1;
        if (items_sent >= 33 + (m + 1) * PhaseItems) n = PhaseItems;
      end
      drain_wait();
    end

    repeat (12) @(posedge clk);
    if (sb.error_count == 0 && sb.expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/bli_pkg.sv
hdl/bli_in_if.sv
hdl/bli_out_if.sv
hdl/bli_front.sv
hdl/bli_queue.sv
hdl/bli_back.sv
hdl/bullet_line_break_inserter.sv
hdl/bli_checker.sv
dv/tb_top.sv
